>>> hdl/sliding_window_congestion_sender_unit_macros.svh
// Assertion macros shared by the checker of the sender unit.
// No dependencies.
`ifndef SLIDING_WINDOW_CONGESTION_SENDER_UNIT_MACROS_SVH
`define SLIDING_WINDOW_CONGESTION_SENDER_UNIT_MACROS_SVH
// implication checked on every clock edge outside reset
`define SWC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swc check failed");
// next-cycle implication
`define SWC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swc check failed");
`endif

>>> hdl/swc_pkg.sv
// Package of the sliding-window sender: commands, register indexes, states, control structs.
// No dependencies.
`timescale 1ns / 1ps
package swc_pkg;
    localparam logic [1:0] CMD_ACK  = 2'd0;
    localparam logic [1:0] CMD_SENT = 2'd1;
    localparam logic [1:0] CMD_LOSS = 2'd2;

    localparam logic [2:0] REG_TOTAL    = 3'd0;
    localparam logic [2:0] REG_INIT_RTT = 3'd1;
    localparam logic [2:0] REG_INIT_SST = 3'd2;
    localparam logic [2:0] REG_FIXED    = 3'd3;
    localparam logic [2:0] REG_USE_CW   = 3'd4;
    localparam logic [2:0] REG_DUP_LIM  = 3'd5;
    localparam logic [2:0] REG_SRTT_W   = 3'd6;
    localparam logic [2:0] REG_VAR_W    = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_GROW,
        ST_RTT,
        ST_OUT
    } swc_state_t;

    typedef struct packed {
        logic load;      // capture input item, run event logic
        logic div_start; // start reciprocal
        logic grow;      // apply cwnd growth
        logic rtt;       // apply rtt sample
        logic finish;    // form result
    } swc_cmd_t;

    typedef struct packed {
        logic need_grow;
        logic need_div;
        logic need_rtt;
        logic div_done;
    } swc_stat_t;
endpackage

>>> hdl/swc_ctrl.sv
// Controller state machine of the sliding-window sender.
// Depends on swc_pkg.
`timescale 1ns / 1ps
module swc_ctrl
    import swc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic       out_free,
    input  swc_stat_t  stat,
    output swc_cmd_t   cmd,
    output logic       busy
);
    swc_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIV;
                end
                else if (stat.need_grow)
                begin
                    state_next = ST_GROW;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_GROW;
                end
            end
            ST_GROW:
            begin
                cmd.grow = 1'b1;
                state_next = stat.need_rtt ? ST_RTT : ST_OUT;
            end
            ST_RTT:
            begin
                cmd.rtt = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

>>> hdl/swc_datapath.sv
// Datapath of the sliding-window sender: registers, window state, reciprocal divider, rtt filter.
// Depends on swc_pkg.
`timescale 1ns / 1ps
module swc_datapath
    import swc_pkg::*;
#(
    parameter int MAX_PACKETS = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_idx,
    input  logic [31:0] cfg_val,
    input  logic [1:0]  in_cmd,
    input  logic [12:0] in_ack,
    input  logic [31:0] in_sample,
    input  logic        in_valid_smp,
    input  swc_cmd_t    cmd,
    output swc_stat_t   stat,
    output logic [111:0] result
);
    localparam int CW = $clog2(MAX_PACKETS) + 17;
    localparam logic [CW-1:0] CAP = CW'(MAX_PACKETS) << 16;
    localparam logic [CW-1:0] ONE = CW'(1) << 16;

    logic [12:0] total_reg, init_sst_reg, fixed_reg;
    logic [31:0] init_rtt_reg;
    logic        use_cw_reg;
    logic [7:0]  dup_lim_reg;
    logic [3:0]  aw_reg, bw_reg;

    logic [12:0] next_reg, base_reg, sst_reg;
    logic [7:0]  dup_reg;
    logic        ss_reg;
    logic [CW-1:0] cwnd_reg;
    logic [31:0] srtt_reg, var_reg;
    logic [32:0] rto_reg;
    logic        resend_reg, grow_reg, rtt_flag_reg;
    logic [31:0] smp_reg;

    // restoring divider 2^32 / cwnd, one quotient bit per cycle
    logic [33:0] rem_reg;
    logic [32:0] quo_reg;
    logic [5:0]  cnt_reg;
    logic        div_run_reg;
    logic [33:0] trial;
    logic [33:0] rem_sh;

    logic signed [13:0] ack_s, next_s, base_s;
    logic ack_ge_base;

    assign ack_s  = {in_ack[12], in_ack};
    assign next_s = {1'b0, next_reg};
    assign base_s = {1'b0, base_reg};
    assign ack_ge_base = (ack_s >= base_s);

    // the dividend 2^32 has its only set bit in the first of the 33 steps
    assign rem_sh = {rem_reg[32:0], (cnt_reg == 6'd33)};
    assign trial  = rem_sh - 34'(cwnd_reg);

    assign stat.need_grow = grow_reg;
    assign stat.need_div  = grow_reg && !ss_reg;
    assign stat.need_rtt  = rtt_flag_reg;
    assign stat.div_done  = div_run_reg && (cnt_reg == 6'd0);

    // growth
    logic [CW:0] grown;
    logic [CW-1:0] grown_sat;
    logic [32:0] inc;
    always_comb
    begin
        inc = (cwnd_reg == '0) ? 33'(ONE) : quo_reg;
        if (ss_reg)
        begin
            grown = {1'b0, cwnd_reg} + (CW+1)'(ONE);
        end
        else
        begin
            grown = (CW+1)'({1'b0, cwnd_reg}) + (CW+1)'(inc);
            if (inc > 33'(CAP))
            begin
                grown = (CW+1)'(CAP) + 1'b1;
            end
        end
        grown_sat = (grown > (CW+1)'(CAP)) ? CAP : grown[CW-1:0];
    end

    // rtt filter
    logic [3:0]  a_w, b_w;
    logic [31:0] diff;
    logic [38:0] var_sum, srtt_sum;
    always_comb
    begin
        a_w = (aw_reg > 4'd8) ? 4'd8 : aw_reg;
        b_w = (bw_reg > 4'd8) ? 4'd8 : bw_reg;
        diff = (smp_reg > srtt_reg) ? smp_reg - srtt_reg : srtt_reg - smp_reg;
        var_sum  = 39'(var_reg) * 39'(4'd8 - b_w) + 39'(diff) * 39'(b_w);
        srtt_sum = 39'(srtt_reg) * 39'(a_w) + 39'(smp_reg) * 39'(4'd8 - a_w);
    end

    logic [CW-2:0] half;
    logic [CW-18:0] half_int;
    assign half = cwnd_reg[CW-1:1];
    assign half_int = half[CW-2:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= 13'd1; init_rtt_reg <= 32'd1000000; init_sst_reg <= 13'd64;
            fixed_reg <= 13'd8; use_cw_reg <= 1'b1; dup_lim_reg <= 8'd3;
            aw_reg <= 4'd7; bw_reg <= 4'd2;
            next_reg <= '0; base_reg <= '0; dup_reg <= '0; ss_reg <= 1'b1;
            cwnd_reg <= ONE; sst_reg <= 13'd64; srtt_reg <= 32'd1000000;
            var_reg <= '0; rto_reg <= 33'd2000000;
            resend_reg <= 1'b0; grow_reg <= 1'b0; rtt_flag_reg <= 1'b0;
            smp_reg <= '0; rem_reg <= '0; quo_reg <= '0;
            div_run_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_TOTAL:    total_reg <= cfg_val[12:0];
                    REG_INIT_RTT:
                    begin
                        init_rtt_reg <= cfg_val;
                        srtt_reg <= cfg_val;
                        rto_reg <= {cfg_val, 1'b0};
                    end
                    REG_INIT_SST:
                    begin
                        init_sst_reg <= cfg_val[12:0];
                        sst_reg <= cfg_val[12:0];
                    end
                    REG_FIXED:    fixed_reg <= cfg_val[12:0];
                    REG_USE_CW:   use_cw_reg <= cfg_val[0];
                    REG_DUP_LIM:  dup_lim_reg <= cfg_val[7:0];
                    REG_SRTT_W:   aw_reg <= cfg_val[3:0];
                    REG_VAR_W:    bw_reg <= cfg_val[3:0];
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                resend_reg <= 1'b0;
                grow_reg <= 1'b0;
                rtt_flag_reg <= 1'b0;
                smp_reg <= in_sample;
                case (in_cmd)
                    CMD_ACK:
                    begin
                        if (ack_s >= next_s)
                        begin
                            next_reg <= in_ack + 13'd1;
                        end
                        if (ack_ge_base)
                        begin
                            grow_reg <= 1'b1;
                            base_reg <= in_ack + 13'd1;
                            dup_reg <= '0;
                            rtt_flag_reg <= in_valid_smp;
                        end
                        else if (dup_reg != 8'hFF)
                        begin
                            dup_reg <= dup_reg + 8'd1;
                            resend_reg <= ((dup_reg + 8'd1) == dup_lim_reg);
                        end
                    end
                    CMD_SENT:
                    begin
                        if (next_reg != 13'h1FFF)
                        begin
                            next_reg <= next_reg + 13'd1;
                        end
                    end
                    CMD_LOSS:
                    begin
                        next_reg <= base_reg + 13'd1;
                        if (half > (CW-1)'(ONE << 1))
                        begin
                            sst_reg <= (32'(half_int) > 32'h1FFF) ? 13'h1FFF
                                                                  : 13'(half_int);
                        end
                        else
                        begin
                            sst_reg <= 13'd2;
                        end
                        cwnd_reg <= ONE;
                        ss_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
            if (cmd.div_start)
            begin
                div_run_reg <= 1'b1;
                cnt_reg <= 6'd33;
                rem_reg <= '0;
                quo_reg <= '0;
            end
            else if (div_run_reg && cnt_reg != 6'd0)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (!trial[33] && cwnd_reg != '0)
                begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[31:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[31:0], 1'b0};
                end
            end
            else if (div_run_reg)
            begin
                div_run_reg <= 1'b0;
            end
            if (cmd.grow)
            begin
                cwnd_reg <= grown_sat;
                if (ss_reg && (32'(grown_sat[CW-1:16]) >= 32'(sst_reg)))
                begin
                    ss_reg <= 1'b0;
                end
            end
            if (cmd.rtt)
            begin
                var_reg <= var_sum[34:3];
                srtt_reg <= srtt_sum[34:3];
                rto_reg <= {srtt_sum[34:3], 1'b0};
            end
        end
    end

    // result
    logic [CW-17:0] cw_int;
    logic [31:0] win;
    logic signed [14:0] gap;
    logic can_send, fin;
    assign cw_int = cwnd_reg[CW-1:16];
    assign win = use_cw_reg ? 32'(cw_int) : 32'(fixed_reg);
    assign gap = 15'(next_s) - 15'(base_s);
    assign can_send = (33'(gap) < $signed({1'b0, win})) && (next_reg < total_reg);
    assign fin = (next_reg == total_reg) && (base_reg == total_reg);
    assign result = {5'd0, rto_reg, srtt_reg, base_reg, next_reg, fin, win[12:0],
                     resend_reg, can_send};
endmodule

>>> hdl/sliding_window_congestion_sender_unit.sv
// Top level of the sliding-window congestion sender.
// Depends on swc_pkg, swc_ctrl, swc_datapath.
//
//  channel  | signals                                | item
//  ---------+----------------------------------------+-------------------------------
//  s_axis   | s_axis_tvalid/tready/tuser[1:0]/tdata[47:0] | event: cmd, ack, sample, valid
//  m_axis   | m_axis_tvalid/tready/tdata[111:0]      | state after the event
//  cfg      | cfg_valid/ready, cfg_index, data       | register write
//
// Steps: an ack in congestion avoidance goes through accept, execute, divide
// (one-bit-per-cycle reciprocal 2^32/cwnd), grow, rtt if sampled, output;
// a slow-start ack skips divide; send, loss, duplicate, unused events skip to output.
// One event is in flight at a time; the result sits in an output register
// until taken while the next event may already be accepted. A full output
// register holds the controller in its output step and so stalls the input.
// Reset (rst_n low, asynchronous) loads all register defaults at once.
`timescale 1ns / 1ps
module sliding_window_congestion_sender_unit
    import swc_pkg::*;
#(
    parameter int MAX_PACKETS = 4096
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [1:0]   s_axis_tuser,  // cmd[1:0]
    input  logic [47:0]  s_axis_tdata,  // ack_num[12:0], rtt_sample_us[44:13],
                                        // sample_valid[45], zero fill
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,  // can_send, resend_needed, window_packets, finished,
                                        // next_index, base_index, srtt_out_us, rto_out_us
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    swc_cmd_t  cmd;
    swc_stat_t stat;
    logic busy, in_fire, out_free;
    logic [111:0] result;
    logic out_valid_reg;
    logic [111:0] out_data_reg;

    assign s_axis_tready = !busy;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    // the output register frees when empty or being drained
    assign out_free = !out_valid_reg || m_axis_tready;
    assign cfg_ready = 1'b1;

    swc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
        .stat(stat), .cmd(cmd), .busy(busy)
    );

    // the request fields are taken straight off the bus at the accepting edge
    swc_datapath #(.MAX_PACKETS(MAX_PACKETS)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_valid && cfg_ready), .cfg_idx(cfg_index), .cfg_val(cfg_data),
        .in_cmd(s_axis_tuser), .in_ack(s_axis_tdata[12:0]),
        .in_sample(s_axis_tdata[44:13]), .in_valid_smp(s_axis_tdata[45]),
        .cmd(cmd), .stat(stat), .result(result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;
endmodule

>>> hdl/swc_checker.sv
// Port-level checker for the sender unit, bound to the top level.
// Depends on sliding_window_congestion_sender_unit_macros.svh.
`timescale 1ns / 1ps
`include "sliding_window_congestion_sender_unit_macros.svh"
module swc_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [111:0] m_axis_tdata
);
    `SWC_ASSERT_NXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `SWC_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `SWC_ASSERT_IMP(a_no_result_idle, clk, rst_n, $rose(m_axis_tvalid), !$past(s_axis_tready))
endmodule

bind sliding_window_congestion_sender_unit swc_checker u_swc_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
